[src/nlc_pkg.sv]
// Types and constants shared by the normalized Legendre column unit.
package nlc_pkg;

    typedef struct packed {
        logic [5:0]         degree_max;
        logic [5:0]         order;
        logic signed [31:0] arg_x;
    } t_in;

    typedef struct packed {
        logic [5:0]         degree;
        logic signed [31:0] value;
        logic               last;
        logic               bad_args;
    } t_out;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_ERR, ST_OMX, ST_SLOOP, ST_SM1, ST_SM2, ST_SD,
        ST_T, ST_U, ST_SQ1, ST_SQ2, ST_DEG, ST_A1, ST_A2,
        ST_R1, ST_R2, ST_R3, ST_R4, ST_R5, ST_EMIT
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_ERR, OP_OMX, OP_SM1, OP_SM2, OP_SD,
        OP_T, OP_U, OP_SQ1, OP_SQ2, OP_DEG, OP_A1, OP_A2,
        OP_R1, OP_R2, OP_R3, OP_R4, OP_R5, OP_EMIT
    } t_op;

    typedef enum logic [1:0] {
        U_MUL, U_DIV, U_SQRT
    } t_unit;

    typedef struct packed {
        t_op  op;
        logic go;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic bad;
        logic seed_more;
        logic ll_le_m;
        logic ll_eq_m1;
        logic ll_last;
    } t_stat;

    localparam logic [63:0]  INV4PI_Q30 = 64'd85445659;
    localparam logic [127:0] LIMIT_MAG  = 128'h1_FFFF_FFFF;
    localparam logic [6:0]   LAST_MUL   = 7'd3;
    localparam logic [6:0]   LAST_DIV   = 7'd63;
    localparam logic [6:0]   LAST_SQRT  = 7'd31;

endpackage

[src/nlc_ctrl.sv]
// Sequencer for the normalized Legendre column unit.
module nlc_ctrl import nlc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_busy
);

    t_state r_state, n_state;
    logic   r_issued;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_issued <= (n_state == r_state) && (r_state != ST_IDLE);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_CHECK;
            ST_CHECK: n_state = i_stat.bad ? ST_ERR : ST_OMX;
            ST_ERR:   n_state = ST_IDLE;
            ST_OMX:   if (i_stat.done) n_state = ST_SLOOP;
            ST_SLOOP: n_state = i_stat.seed_more ? ST_SM1 : ST_T;
            ST_SM1:   if (i_stat.done) n_state = ST_SM2;
            ST_SM2:   if (i_stat.done) n_state = ST_SD;
            ST_SD:    if (i_stat.done) n_state = ST_SLOOP;
            ST_T:     if (i_stat.done) n_state = ST_U;
            ST_U:     if (i_stat.done) n_state = ST_SQ1;
            ST_SQ1:   if (i_stat.done) n_state = ST_SQ2;
            ST_SQ2:   if (i_stat.done) n_state = ST_DEG;
            ST_DEG: begin
                if (i_stat.ll_le_m)       n_state = ST_EMIT;
                else if (i_stat.ll_eq_m1) n_state = ST_A1;
                else                      n_state = ST_R1;
            end
            ST_A1:    if (i_stat.done) n_state = ST_A2;
            ST_A2:    if (i_stat.done) n_state = ST_EMIT;
            ST_R1:    if (i_stat.done) n_state = ST_R2;
            ST_R2:    if (i_stat.done) n_state = ST_R3;
            ST_R3:    if (i_stat.done) n_state = ST_R4;
            ST_R4:    if (i_stat.done) n_state = ST_R5;
            ST_R5:    if (i_stat.done) n_state = ST_EMIT;
            ST_EMIT:  n_state = i_stat.ll_last ? ST_IDLE : ST_DEG;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy   = (r_state != ST_IDLE);
        o_cmd.go = (r_state == ST_IDLE) ? i_start : !r_issued;
        case (r_state)
            ST_IDLE: o_cmd.op = OP_LOAD;
            ST_ERR:  o_cmd.op = OP_ERR;
            ST_OMX:  o_cmd.op = OP_OMX;
            ST_SM1:  o_cmd.op = OP_SM1;
            ST_SM2:  o_cmd.op = OP_SM2;
            ST_SD:   o_cmd.op = OP_SD;
            ST_T:    o_cmd.op = OP_T;
            ST_U:    o_cmd.op = OP_U;
            ST_SQ1:  o_cmd.op = OP_SQ1;
            ST_SQ2:  o_cmd.op = OP_SQ2;
            ST_DEG:  o_cmd.op = OP_DEG;
            ST_A1:   o_cmd.op = OP_A1;
            ST_A2:   o_cmd.op = OP_A2;
            ST_R1:   o_cmd.op = OP_R1;
            ST_R2:   o_cmd.op = OP_R2;
            ST_R3:   o_cmd.op = OP_R3;
            ST_R4:   o_cmd.op = OP_R4;
            ST_R5:   o_cmd.op = OP_R5;
            ST_EMIT: o_cmd.op = OP_EMIT;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

[src/nlc_dp.sv]
// Datapath: operand registers and a shared multiply / divide / square-root unit.
module nlc_dp import nlc_pkg::*; #(
    parameter int MAX_DEGREE = 63,
    parameter int FRAC_BITS  = 24
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_in   i_item,
    input  t_cmd  i_cmd,
    output t_stat o_stat,
    output logic  o_strobe,
    output t_out  o_result
);

    localparam int          SH   = 30 - FRAC_BITS;
    localparam logic [35:0] HALF = (SH == 0) ? 36'd0 : (36'd1 << (SH - 1));

    logic [5:0]         r_lc, r_m, r_ll;
    logic signed [31:0] r_x;
    logic [31:0]        r_ax;
    logic [63:0]        r_omx2, r_pmm, r_tmp, r_oldfact, r_fact;
    logic [6:0]         r_i;
    logic signed [34:0] r_seed, r_p, r_p1, r_p2;
    logic signed [35:0] r_v;

    // shared unit; for square root r_rem holds the remainder, r_ua the root, r_ub the bit
    logic        r_run, r_done;
    t_unit       r_unit;
    logic [6:0]  r_cnt;
    logic [63:0] r_ua, r_ub, r_rem;
    logic [127:0] r_acc;

    logic r_strobe;
    t_out r_out;

    logic [63:0]  a_sel, b_sel;
    t_unit        u_sel;
    logic         unit_op;
    logic [34:0]  p1_mag, p2_mag, p_mag;
    logic [35:0]  v_mag, omag;
    logic [11:0]  ll_sq, m_sq, den;
    logic [13:0]  num;
    logic [6:0]   two_i, m2p1, m2p3;
    logic [1:0]   pp_pos;
    logic [63:0]  pp;
    logic [64:0]  dv_trial, dv_diff, sq_sum;
    logic         dv_ge, sq_ge;
    logic [127:0] acc_r30, acc_r24, mag24;
    logic [63:0]  sqrt_res;
    logic [34:0]  p_new;
    logic [31:0]  out_val;

    assign p1_mag = r_p1[34] ? 35'(-r_p1) : 35'(r_p1);
    assign p2_mag = r_p2[34] ? 35'(-r_p2) : 35'(r_p2);
    assign p_mag  = r_p[34]  ? 35'(-r_p)  : 35'(r_p);
    assign v_mag  = r_v[35]  ? 36'(-r_v)  : 36'(r_v);
    assign ll_sq  = 12'(r_ll * r_ll);
    assign m_sq   = 12'(r_m * r_m);
    assign den    = ll_sq - m_sq;
    assign num    = {ll_sq, 2'b00} - 14'd1;
    assign two_i  = {r_i[5:0], 1'b0};
    assign m2p1   = {r_m, 1'b1};
    assign m2p3   = {r_m, 1'b1} + 7'd2;

    always_comb begin
        a_sel   = '0;
        b_sel   = '0;
        u_sel   = U_MUL;
        unit_op = 1'b1;
        case (i_cmd.op)
            OP_OMX: begin a_sel = 64'(r_ax); b_sel = 64'(r_ax); end
            OP_SM1: begin a_sel = r_pmm; b_sel = r_omx2; end
            OP_SM2: begin a_sel = r_pmm; b_sel = 64'(two_i - 7'd1); end
            OP_SD: begin
                a_sel = r_tmp; b_sel = 64'(two_i); u_sel = U_DIV;
            end
            OP_T:   begin a_sel = 64'(m2p1); b_sel = r_pmm; end
            OP_U:   begin a_sel = r_tmp; b_sel = INV4PI_Q30; end
            OP_SQ1: begin a_sel = r_tmp << 30; u_sel = U_SQRT; end
            OP_SQ2: begin a_sel = 64'(m2p3) << 48; u_sel = U_SQRT; end
            OP_A1, OP_R3: begin a_sel = 64'(r_ax); b_sel = 64'(p1_mag); end
            OP_A2:  begin a_sel = 64'(v_mag); b_sel = r_oldfact; end
            OP_R1: begin
                a_sel = 64'({num, 48'd0}); b_sel = 64'(den); u_sel = U_DIV;
            end
            OP_R2:  begin a_sel = r_tmp; u_sel = U_SQRT; end
            OP_R4: begin
                a_sel = (64'(p2_mag) << 24) + (r_oldfact >> 1);
                b_sel = r_oldfact;
                u_sel = U_DIV;
            end
            OP_R5:  begin a_sel = 64'(v_mag); b_sel = r_fact; end
            default: unit_op = 1'b0;
        endcase
    end

    assign pp_pos   = {1'b0, r_cnt[1]} + {1'b0, r_cnt[0]};
    assign pp       = 64'(r_ua[{r_cnt[1], 5'd0} +: 32]) * 64'(r_ub[{r_cnt[0], 5'd0} +: 32]);
    assign dv_trial = {r_rem, r_ua[63]};
    assign dv_ge    = dv_trial >= {1'b0, r_ub};
    assign dv_diff  = dv_trial - {1'b0, r_ub};
    assign sq_sum   = {1'b0, r_ua} + {1'b0, r_ub};
    assign sq_ge    = {1'b0, r_rem} >= sq_sum;
    assign sqrt_res = r_ua + {63'd0, (r_rem > r_ua)};
    assign acc_r30  = (r_acc + (128'd1 << 29)) >> 30;
    assign acc_r24  = (r_acc + (128'd1 << 23)) >> 24;
    assign mag24    = (acc_r24 > LIMIT_MAG) ? LIMIT_MAG : acc_r24;
    assign p_new    = r_v[35] ? 35'(-mag24[34:0]) : mag24[34:0];

    assign omag = (36'(p_mag) + HALF) >> SH;
    always_comb begin
        if (!r_p[34]) begin
            out_val = (omag > 36'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : omag[31:0];
        end else begin
            out_val = (omag > 36'h0_8000_0000) ? 32'h8000_0000 : (~omag[31:0] + 32'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run    <= 1'b0;
            r_done   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_done   <= 1'b0;
            r_strobe <= 1'b0;
            if (i_cmd.go && unit_op) begin
                r_run <= 1'b1;
            end else if (r_run) begin
                if ((r_unit == U_MUL && r_cnt == LAST_MUL)
                    || (r_unit == U_DIV && r_cnt == LAST_DIV)
                    || (r_unit == U_SQRT && r_cnt == LAST_SQRT)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
            if (i_cmd.go && (i_cmd.op == OP_ERR || i_cmd.op == OP_EMIT)) begin
                r_strobe <= 1'b1;
            end
        end
    end

    // shared unit iterations
    always_ff @(posedge i_clk) begin
        if (i_cmd.go && unit_op) begin
            r_unit <= u_sel;
            r_cnt  <= '0;
            r_acc  <= '0;
            case (u_sel)
                U_SQRT: begin
                    r_rem <= a_sel;
                    r_ua  <= '0;
                    r_ub  <= 64'd1 << 62;
                end
                default: begin
                    r_rem <= '0;
                    r_ua  <= a_sel;
                    r_ub  <= b_sel;
                end
            endcase
        end else if (r_run) begin
            r_cnt <= r_cnt + 7'd1;
            case (r_unit)
                U_MUL: r_acc <= r_acc + ({64'd0, pp} << {pp_pos, 5'd0});
                U_DIV: begin
                    r_rem <= dv_ge ? dv_diff[63:0] : dv_trial[63:0];
                    r_ua  <= {r_ua[62:0], dv_ge};
                end
                U_SQRT: begin
                    if (sq_ge) begin
                        r_rem <= r_rem - sq_sum[63:0];
                        r_ua  <= (r_ua >> 1) + r_ub;
                    end else begin
                        r_ua  <= r_ua >> 1;
                    end
                    r_ub <= r_ub >> 2;
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // operand registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.go) begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_x  <= i_item.arg_x;
                    r_ax <= i_item.arg_x[31] ? (~i_item.arg_x + 32'd1) : i_item.arg_x;
                    r_m  <= i_item.order;
                    r_lc <= ({2'b00, i_item.degree_max} > 8'(MAX_DEGREE))
                            ? 6'(MAX_DEGREE) : i_item.degree_max;
                end
                OP_ERR: r_out <= '{degree: '0, value: '0, last: 1'b1, bad_args: 1'b1};
                OP_DEG: r_p <= (r_ll == r_m) ? r_seed : '0;
                OP_EMIT: begin
                    r_out <= '{degree: r_ll, value: out_val,
                               last: (r_ll == r_lc), bad_args: 1'b0};
                    r_p2  <= r_p1;
                    r_p1  <= r_p;
                    r_ll  <= r_ll + 6'd1;
                end
                default: r_ll <= r_ll;
            endcase
        end
        if (r_done) begin
            case (i_cmd.op)
                OP_OMX: begin
                    r_omx2 <= (((64'd1 << 60) - r_acc[63:0]) + (64'd1 << 29)) >> 30;
                    r_pmm  <= 64'd1 << 30;
                    r_i    <= 7'd1;
                end
                OP_SM1: r_pmm <= acc_r30[63:0];
                OP_SM2: r_tmp <= r_acc[63:0] + 64'(r_i);
                OP_SD: begin
                    r_pmm <= r_ua;
                    r_i   <= r_i + 7'd1;
                end
                OP_T:   r_tmp <= r_acc[63:0];
                OP_U:   r_tmp <= acc_r30[63:0];
                OP_SQ1: r_seed <= r_m[0] ? 35'(-sqrt_res[34:0]) : sqrt_res[34:0];
                OP_SQ2: begin
                    r_oldfact <= sqrt_res;
                    r_ll      <= '0;
                    r_p1      <= '0;
                    r_p2      <= '0;
                end
                OP_A1, OP_R3:
                    r_v <= (r_x[31] ^ r_p1[34]) ? 36'(-acc_r30[35:0]) : acc_r30[35:0];
                OP_A2:  r_p <= p_new;
                OP_R1:  r_tmp <= r_ua + {63'd0, (r_rem >= 64'((den + 12'd1) >> 1))};
                OP_R2:  r_fact <= sqrt_res;
                OP_R4:  r_v <= r_p2[34] ? (r_v + 36'(r_ua)) : (r_v - 36'(r_ua));
                OP_R5: begin
                    r_p       <= p_new;
                    r_oldfact <= r_fact;
                end
                default: r_tmp <= r_tmp;
            endcase
        end
    end

    assign o_stat.done      = r_done;
    assign o_stat.bad       = (r_m > r_lc) || (r_x > 32'sh4000_0000) || (r_x < -32'sh4000_0000);
    assign o_stat.seed_more = r_i <= {1'b0, r_m};
    assign o_stat.ll_le_m   = r_ll <= r_m;
    assign o_stat.ll_eq_m1  = {1'b0, r_ll} == ({1'b0, r_m} + 7'd1);
    assign o_stat.ll_last   = r_ll == r_lc;
    assign o_strobe         = r_strobe;
    assign o_result         = r_out;

endmodule

[src/normalized_legendre_column_unit.sv]
// Top level of the normalized associated Legendre column unit.
// An item is taken when start is high and busy is low; results for degrees 0..l then leave
// one per o_strobe pulse, which the receiver must take in that cycle. Bad arguments give one
// error result. Here l is the degree clamped to MAX_DEGREE. The last result appears in the
// first cycle with busy low. All work runs through one shared iterative unit; each operation
// is issued, iterated and then finished: a multiply accumulates 32x32 partial products, a
// divide yields one quotient bit per cycle and a square root one root bit per cycle.
module normalized_legendre_column_unit import nlc_pkg::*; #(
    parameter int MAX_DEGREE = 63,
    parameter int FRAC_BITS  = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_in  i_item,
    output logic busy,
    output logic o_strobe,
    output t_out o_result
);

    t_cmd  cmd;
    t_stat stat;

    nlc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    nlc_dp #(
        .MAX_DEGREE (MAX_DEGREE),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule

[src/nlc_checker.sv]
// Port-level assertions for the normalized Legendre column unit, with its bind.
module nlc_checker import nlc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input t_out o_result
);

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.bad_args |-> o_result.last)
        else $error("error item not marked last");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.bad_args |-> o_result.value == 0 && o_result.degree == 0)
        else $error("error item carries data");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |-> busy)
        else $error("idle with items outstanding");

    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |=> !o_strobe)
        else $error("back-to-back result strobes");

endmodule

bind normalized_legendre_column_unit nlc_checker u_nlc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

[tb/sv/normalized_legendre_column_unit_test.sv]
// Testbench for the normalized associated Legendre column unit: queued driver, monitor, predictor.
`timescale 1ns / 100ps
module normalized_legendre_column_unit_test;
    import nlc_pkg::*;

    typedef struct {
        t_in item;
        int  gap_pct;
        bit  drain;
    } t_pending;

    logic i_clk;
    logic i_rst_n;
    logic start;
    t_in  i_item;
    logic busy;
    logic o_strobe;
    t_out o_result;

    t_pending pending_items[$];
    t_out     legendre_values[$];
    int       mismatches;
    int       items_sent;
    int       values_seen;
    int       bad_items;
    bit       stim_done;

    normalized_legendre_column_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_item  (i_item),
        .busy    (busy),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic longint round_shift(longint v, int s);
        longint unsigned mag;
        if (s == 0) return v;
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'd1 << (s - 1))) >> s;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint round_div(longint v, longint unsigned d);
        longint unsigned mag;
        mag = (v < 0) ? -v : v;
        mag = (mag + d / 2) / d;
        return (v < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint unsigned isqrt_nearest(longint unsigned n);
        longint unsigned r;
        longint unsigned bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n = n - (r + bitv);
                r = (r >> 1) + bitv;
            end else begin
                r = r >> 1;
            end
            bitv = bitv >> 2;
        end
        if (n > r) r++;
        return r;
    endfunction

    function automatic longint sat_q30(longint v);
        longint lim;
        lim = (64'sd1 <<< 33) - 1;
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    task automatic predict_column(input t_in it);
        longint unsigned l, m, ax, omx2, pmm, t, u, ll, num, den, ratio;
        longint x, seed, p1, p2, p, oldfact, fact, v;
        t_out r;
        l = it.degree_max;
        m = it.order;
        x = it.arg_x;
        p1 = 0;
        p2 = 0;
        if (l > 63) l = 63;
        if (m > l || x > (64'sd1 <<< 30) || x < -(64'sd1 <<< 30)) begin
            r.degree = '0;
            r.value = '0;
            r.last = 1'b1;
            r.bad_args = 1'b1;
            legendre_values.push_back(r);
            bad_items++;
            return;
        end
        ax = (x < 0) ? -x : x;
        omx2 = ((64'd1 << 60) - ax * ax + (64'd1 << 29)) >> 30;
        pmm = 64'd1 << 30;
        for (longint unsigned i = 1; i <= m; i++) begin
            pmm = (pmm * omx2 + (64'd1 << 29)) >> 30;
            pmm = (pmm * (2 * i - 1) + i) / (2 * i);
        end
        t = (2 * m + 1) * pmm;
        u = (t * INV4PI_Q30 + (64'd1 << 29)) >> 30;
        seed = isqrt_nearest(u << 30);
        if (m[0]) seed = -seed;
        seed = sat_q30(seed);
        oldfact = isqrt_nearest((2 * m + 3) << 48);
        for (ll = 0; ll <= l; ll++) begin
            if (ll < m) begin
                p = 0;
            end else if (ll == m) begin
                p = seed;
            end else if (ll == m + 1) begin
                p = round_shift(x * p1, 30);
                p = sat_q30(round_shift(p * oldfact, 24));
            end else begin
                num = 4 * ll * ll - 1;
                den = ll * ll - m * m;
                ratio = (num << 48) / den;
                if ((num << 48) % den >= (den + 1) / 2) ratio++;
                fact = isqrt_nearest(ratio);
                v = round_shift(x * p1, 30) - round_div(p2 * (64'sd1 <<< 24), oldfact);
                p = sat_q30(round_shift(v * fact, 24));
                oldfact = fact;
            end
            p2 = p1;
            p1 = p;
            v = round_shift(p, 6);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            r.degree = ll[5:0];
            r.value = v[31:0];
            r.last = (ll == l);
            r.bad_args = 1'b0;
            legendre_values.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_item <= '0;
        end else if (start && busy) begin
            start <= 1'b1;
        end else begin
            if (start) begin
                predict_column(i_item);
                items_sent++;
            end
            if (pending_items.size() > 0
                && !(pending_items[0].drain && (start || legendre_values.size() > 0 || busy))
                && $urandom_range(99) >= pending_items[0].gap_pct) begin
                i_item <= pending_items.pop_front().item;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_strobe) begin
            values_seen++;
            if (legendre_values.size() == 0) begin
                report_mismatch("unexpected item degree", o_result.degree, -1);
            end else begin
                want = legendre_values.pop_front();
                if (o_result.degree !== want.degree)
                    report_mismatch("degree", o_result.degree, want.degree);
                if (o_result.value !== want.value)
                    report_mismatch("value", o_result.value, want.value);
                if (o_result.last !== want.last)
                    report_mismatch("last", o_result.last, want.last);
                if (o_result.bad_args !== want.bad_args)
                    report_mismatch("bad_args", o_result.bad_args, want.bad_args);
            end
        end
    end

    task automatic queue_item(input int l, input int m, input logic [31:0] x,
                              input int gap, input bit drain);
        t_pending e;
        e.item.degree_max = 6'(l);
        e.item.order = 6'(m);
        e.item.arg_x = x;
        e.gap_pct = gap;
        e.drain = drain;
        pending_items.push_back(e);
    endtask

    initial begin
        int l, m, gap;
        logic [31:0] x;
        start = 1'b0;
        i_item = '0;
        mismatches = 0;
        items_sent = 0;
        values_seen = 0;
        bad_items = 0;
        i_rst_n = 1'b0;
        queue_item(0, 0, 32'h0000_0000, 0, 0);
        queue_item(3, 0, 32'h4000_0000, 0, 0);
        queue_item(3, 1, 32'hC000_0000, 0, 0);
        queue_item(5, 2, 32'h2000_0000, 0, 0);
        queue_item(4, 3, 32'hE000_0000, 0, 0);
        queue_item(63, 0, 32'h1000_0000, 0, 0);
        queue_item(63, 63, 32'h0000_0000, 0, 0);
        queue_item(63, 62, 32'h0800_0000, 0, 0);
        queue_item(63, 40, 32'h3FFF_FFFF, 0, 0);
        queue_item(10, 10, 32'h4000_0000, 0, 0);
        queue_item(2, 3, 32'h0000_0000, 0, 0);
        queue_item(0, 63, 32'h0000_0000, 0, 0);
        queue_item(5, 1, 32'h4000_0001, 0, 0);
        queue_item(5, 1, 32'hBFFF_FFFF, 0, 0);
        queue_item(5, 1, 32'h7FFF_FFFF, 0, 0);
        queue_item(5, 1, 32'h8000_0000, 0, 0);
        queue_item(6, 0, 32'hFFFF_FFFF, 0, 0);
        queue_item(8, 4, 32'h3FFF_0000, 0, 0);
        queue_item(12, 1, 32'hD555_5555, 0, 0);
        queue_item(1, 1, 32'h2AAA_AAAA, 0, 0);
        for (int k = 0; k < 120; k++) begin
            case (k / 30)
                0: gap = 0;
                1: gap = 55;
                2: gap = 0;
                default: gap = 27;
            endcase
            l = ($urandom_range(19) == 0) ? $urandom_range(63) : $urandom_range(12);
            m = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(l);
            if ($urandom_range(7) == 0) x = $urandom;
            else x = $urandom_range(32'h8000_0000) - 32'h4000_0000;
            queue_item(l, m, x, gap, (k % 30) == 0);
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_items.size() == 0);
        @(posedge i_clk);
        while (start || legendre_values.size() > 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (legendre_values.size() != 0) begin
            $display("%0d expected values never arrived", legendre_values.size());
            mismatches++;
        end
        $display("ran %0d items (%0d with bad arguments), checked %0d values",
                 items_sent, bad_items, values_seen);
        $display("covered degrees up to 63, orders up to 63, x over the full 32-bit range");
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #200ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
